>>> hdl/sem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the rgb sobel edge magnitude block
// Holds the state encoding, the pixel/channel/sum widths and the action codes.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int PIX_W  = 24;
   localparam int CHAN_W = 8;
   localparam int SUM_W  = 21;   // gx*gx+gy*gy < 2^21

   localparam logic [0:0] ACT_PIXEL = 1'b0;
   localparam logic [0:0] ACT_FLUSH = 1'b1;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              eof;
      logic              eor;
   } result_type;

endpackage

>>> hdl/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 sobel magnitude on rgb pixels
// Two line memories hold the previous rows; a two-column window of six pixels
// feeds the kernels and a bit-serial square root finishes each channel.
// ----------------------------------------------------------------------------
// sequence: an accepted word is read, passes the kernel, 8 square root steps
//    and the load of the result register; a second result repeats all but the read
// flow: a new word is taken only in the idle state, once every result of the
//    last word is loaded; output stalls keep the block busy
// reset: synchronous; counters and window cleared, width 640, height 480;
//    line memories are not cleared, rows not yet written are masked to zero
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue_in, green_in, red_in
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // blue_edge, green_edge, red_edge, end_of_frame, pad
   output logic        rsp_tlast    // end_of_run
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   sem_pkg::state_type state_ff, state_in;

   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [CW-1:0] eff_w;
   logic [15:0]   eff_h;

   logic [15:0]   in_row_ff;
   logic [CW-1:0] in_col_ff;
   logic [15:0]   out_row_ff;
   logic [CW-1:0] out_col_ff;

   sem_pkg::pixel_type upper_mem [MAX_WIDTH];
   sem_pkg::pixel_type middle_mem [MAX_WIDTH];
   sem_pkg::pixel_type upper_rd_ff, middle_rd_ff;

   sem_pkg::pixel_type win_ff [6];
   sem_pkg::pixel_type pix_ff;
   logic              second_ff;   // a second result pending for this word
   logic              first_ff;    // first pass of this word is done
   logic              eor_ff;

   // kernel operands for the current result
   sem_pkg::pixel_type kl [3];
   sem_pkg::pixel_type km [3];
   sem_pkg::pixel_type kr [3];
   logic [sem_pkg::SUM_W-1:0] sq_ff [3];
   logic [sem_pkg::SUM_W-1:0] sq_in [3];
   logic [7:0] root_ff [3];
   logic [2:0] bit_ff;
   sem_pkg::result_type res_ff;
   logic rsp_valid_ff;

   logic [AW-1:0] addr;
   logic accept, cfg_hit;
   logic is_flush;
   logic rowlast;
   logic has_first, has_last;
   logic emit_load;

   always_comb begin
      if (width_ff == 11'd0)
         eff_w = CW'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         eff_w = CW'(MAX_WIDTH);
      else
         eff_w = CW'(width_ff);
      eff_h = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end

   assign addr    = in_col_ff[AW-1:0];
   assign accept  = req_tvalid && req_tready;
   assign cfg_hit = csr_we;
   assign is_flush = (req_tuser == sem_pkg::ACT_FLUSH);
   assign req_tready = (state_ff == sem_pkg::ST_IDLE) && !reset;

   assign rowlast   = (in_col_ff == eff_w - CW'(1));
   assign has_first = (in_row_ff >= 16'd1) && (in_col_ff >= CW'(1));
   assign has_last  = (in_row_ff >= 16'd1) && rowlast;
   // result register is free or drains this cycle
   assign emit_load = (state_ff == sem_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sem_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_flush ? (in_row_ff == eff_h) : (in_row_ff < eff_h))
                  state_in = sem_pkg::ST_READ;
            end
         end
         sem_pkg::ST_READ: state_in = sem_pkg::ST_CALC;
         sem_pkg::ST_CALC: begin
            if (first_ff || has_first)
               state_in = sem_pkg::ST_ROOT;
            else if (has_last)
               state_in = sem_pkg::ST_CALC;
            else
               state_in = sem_pkg::ST_IDLE;
         end
         sem_pkg::ST_ROOT: state_in = (bit_ff == 3'd0) ? sem_pkg::ST_EMIT : sem_pkg::ST_ROOT;
         sem_pkg::ST_EMIT: begin
            if (emit_load)
               state_in = second_ff ? sem_pkg::ST_CALC : sem_pkg::ST_IDLE;
         end
         default: state_in = sem_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sem_pkg::ST_IDLE;
      else if (cfg_hit) state_ff <= sem_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // line memories: read at accept, write back in the read step
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff  <= upper_mem[addr];
         middle_rd_ff <= middle_mem[addr];
      end
      if (state_ff == sem_pkg::ST_READ && in_row_ff < eff_h) begin
         upper_mem[addr]  <= middle_rd_ff;
         middle_mem[addr] <= pix_ff;
      end
   end

   // kernel operand selection: first result uses the incoming column,
   // the row-end second result uses a zero column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         kl[i] = win_ff[i];
         km[i] = win_ff[3+i];
         kr[i] = '0;
      end
   end

   function automatic logic [sem_pkg::SUM_W-1:0] sobel_sq(
      input sem_pkg::pixel_type l0, input sem_pkg::pixel_type l1,
      input sem_pkg::pixel_type l2, input sem_pkg::pixel_type m0,
      input sem_pkg::pixel_type m2, input sem_pkg::pixel_type r0,
      input sem_pkg::pixel_type r1, input sem_pkg::pixel_type r2,
      input int sh);
      logic signed [11:0] gx, gy;
      logic signed [21:0] gx_w, gy_w;
      logic [21:0] s;
      gx = -$signed({4'd0, l0[sh+:8]}) + $signed({4'd0, r0[sh+:8]})
           - ($signed({4'd0, l1[sh+:8]}) <<< 1) + ($signed({4'd0, r1[sh+:8]}) <<< 1)
           - $signed({4'd0, l2[sh+:8]}) + $signed({4'd0, r2[sh+:8]});
      gy = -$signed({4'd0, l0[sh+:8]}) - ($signed({4'd0, m0[sh+:8]}) <<< 1)
           - $signed({4'd0, r0[sh+:8]}) + $signed({4'd0, l2[sh+:8]})
           + ($signed({4'd0, m2[sh+:8]}) <<< 1) + $signed({4'd0, r2[sh+:8]});
      gx_w = 22'(gx);
      gy_w = 22'(gy);
      s = $unsigned(gx_w * gx_w) + $unsigned(gy_w * gy_w);
      return s[sem_pkg::SUM_W-1:0];
   endfunction

   // the right column: live column for the first result, zero for the second
   sem_pkg::pixel_type colr [3];
   always_comb begin
      if (!first_ff) begin
         colr[0] = (in_row_ff >= 16'd2) ? upper_rd_ff : '0;
         colr[1] = (in_row_ff >= 16'd1) ? middle_rd_ff : '0;
         colr[2] = pix_ff;
      end else begin
         colr[0] = kr[0];
         colr[1] = kr[1];
         colr[2] = kr[2];
      end
      for (int k = 0; k < 3; k++)
         sq_in[k] = sobel_sq(kl[0], kl[1], kl[2], km[0], km[2],
                             colr[0], colr[1], colr[2], 16 - 8 * k);
   end

   // per word control, window shift, root iteration and output
   logic [8:0] trial [3];
   always_comb begin
      for (int k = 0; k < 3; k++)
         trial[k] = {1'b0, root_ff[k] | (8'd1 << bit_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         in_row_ff <= '0; in_col_ff <= '0; out_row_ff <= '0; out_col_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff <= 1'b0; second_ff <= 1'b0;
      end else begin
         if (emit_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            sem_pkg::ST_IDLE: begin
               if (accept) begin
                  pix_ff   <= is_flush ? '0 : req_tdata;
                  first_ff <= 1'b0;
               end
            end
            sem_pkg::ST_READ: begin
               second_ff <= 1'b0;
            end
            sem_pkg::ST_CALC: begin
               if (!first_ff) begin
                  // first pass: maybe produce with live column, then shift
                  for (int k = 0; k < 3; k++) sq_ff[k] <= sq_in[k];
                  for (int i = 0; i < 3; i++) begin
                     win_ff[i]   <= (in_col_ff == '0) ? '0 : win_ff[3+i];
                     win_ff[3+i] <= colr[i];
                  end
                  first_ff  <= 1'b1;
                  second_ff <= has_last;
                  eor_ff    <= !has_last;
                  if (rowlast) begin
                     in_col_ff <= '0;
                     in_row_ff <= (in_row_ff >= eff_h) ? 16'd0 : in_row_ff + 16'd1;
                  end else begin
                     in_col_ff <= in_col_ff + CW'(1);
                  end
               end else begin
                  for (int k = 0; k < 3; k++) sq_ff[k] <= sq_in[k];
                  second_ff <= 1'b0;
                  eor_ff    <= 1'b1;
               end
               for (int k = 0; k < 3; k++) root_ff[k] <= '0;
               bit_ff <= 3'd7;
            end
            sem_pkg::ST_ROOT: begin
               // keep bit when (t)*(t-1) < s, i.e. round-half-up root
               for (int k = 0; k < 3; k++)
                  if ((21'(trial[k]) * 21'(trial[k] - 9'd1)) < sq_ff[k])
                     root_ff[k] <= trial[k][7:0];
               bit_ff <= bit_ff - 3'd1;
            end
            sem_pkg::ST_EMIT: begin
               if (emit_load) begin
                  res_ff.red   <= root_ff[0];
                  res_ff.green <= root_ff[1];
                  res_ff.blue  <= root_ff[2];
                  res_ff.eof   <= (out_row_ff == eff_h - 16'd1) &&
                                  (out_col_ff == eff_w - CW'(1));
                  res_ff.eor   <= eor_ff;
                  if (out_col_ff + CW'(1) >= eff_w) begin
                     out_col_ff <= '0;
                     out_row_ff <= (out_row_ff + 16'd1 >= eff_h) ? 16'd0
                                                                 : out_row_ff + 16'd1;
                  end else begin
                     out_col_ff <= out_col_ff + CW'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 16'd480;
      end else if (csr_we) begin
         if (csr_index == sem_pkg::REG_WIDTH) width_ff <= csr_wdata[10:0];
         else height_ff <= csr_wdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.eof, res_ff.red, res_ff.green, res_ff.blue};
   assign rsp_tlast  = res_ff.eor;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sem_pkg::ST_IDLE) |-> !req_tready)
      else $error("word accepted while busy");
   a_hold_result: assert property (@(posedge clock) disable iff (reset || csr_we)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("result dropped");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      in_col_ff < eff_w || in_col_ff == '0)
      else $error("column out of range");

endmodule
